### sv/fqmr_pkg.sv
// Shared types and constants for the FIFO queue with max removal.
// Operation and status codes, chain control struct, controller states.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package fqmr_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int DATA_W          = 32;
    localparam int COUNT_OUT_W     = 5;
    localparam int STATUS_W        = 2;

    localparam logic signed [DATA_W-1:0] FRONT_EMPTY = -32'sd1;
    localparam logic signed [DATA_W-1:0] VALUE_ZERO  = 32'sd0;

    typedef enum logic [1:0] {
        MODE_PUSH       = 2'd0,
        MODE_POP        = 2'd1,
        MODE_REMOVE_MAX = 2'd2,
        MODE_QUERY      = 2'd3
    } mode_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK    = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_FULL  = 2'd2
    } status_t;

    // What every cell of the entry chain does this cycle.
    typedef enum logic [1:0] {
        CHAIN_HOLD,
        CHAIN_PUSH,
        CHAIN_CLOSE,
        CHAIN_ROTATE
    } chain_op_t;

    typedef struct packed {
        chain_op_t                op;
        logic signed [DATA_W-1:0] data;
    } chain_ctrl_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_REMOVE,
        S_DONE
    } state_t;

endpackage

`default_nettype wire

### sv/fqmr_req_if.sv
// Request channel: one queue operation per request.
// Depends on fqmr_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface fqmr_req_if;
    import fqmr_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [1:0]               mode;
    logic signed [DATA_W-1:0] value_in;

    modport source (output valid, output mode, output value_in, input ready);
    modport sink   (input valid, input mode, input value_in, output ready);
endinterface

`default_nettype wire

### sv/fqmr_rsp_if.sv
// Response channel: queue snapshot after each request.
// Depends on fqmr_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface fqmr_rsp_if;
    import fqmr_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] removed_value;
    logic signed [DATA_W-1:0] front_value;
    logic signed [DATA_W-1:0] max_value;
    logic [COUNT_OUT_W-1:0]   entry_count;
    logic [STATUS_W-1:0]      status;

    modport source (output valid, output removed_value, output front_value,
                    output max_value, output entry_count, output status,
                    input ready);
    modport sink   (input valid, input removed_value, input front_value,
                    input max_value, input entry_count, input status,
                    output ready);
endinterface

`default_nettype wire

### sv/fqmr_cell.sv
// One storage cell of the entry chain; position IDX from the front.
// Loads on push, closes up from its right neighbor, or rotates.
// Depends on fqmr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fqmr_cell #(
    parameter int IDX = 0,
    parameter int CW  = 5
) (
    input  wire logic                             clk,
    input  wire fqmr_pkg::chain_ctrl_t            ctrl,
    input  wire logic [CW-1:0]                    pos,
    input  wire logic signed [fqmr_pkg::DATA_W-1:0] right,
    input  wire logic signed [fqmr_pkg::DATA_W-1:0] head,
    output logic signed [fqmr_pkg::DATA_W-1:0]      value
);
    import fqmr_pkg::*;

    localparam logic [CW-1:0] MY_POS = CW'(IDX);

    logic signed [DATA_W-1:0] value_reg;
    logic signed [DATA_W-1:0] value_next;

    always_comb
    begin
        value_next = value_reg;
        unique case (ctrl.op)
            CHAIN_HOLD:
            begin
                value_next = value_reg;
            end
            CHAIN_PUSH:
            begin
                if (MY_POS == pos)
                begin
                    value_next = ctrl.data;
                end
            end
            CHAIN_CLOSE:
            begin
                // pos is the slot being removed; everything behind moves up
                if (MY_POS >= pos)
                begin
                    value_next = right;
                end
            end
            CHAIN_ROTATE:
            begin
                // pos is the last occupied slot; it takes the old front
                if (MY_POS < pos)
                begin
                    value_next = right;
                end
                else if (MY_POS == pos)
                begin
                    value_next = head;
                end
            end
            default:
            begin
                value_next = value_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;

endmodule

`default_nettype wire

### sv/fifo_queue_with_max_removal_unit.sv
// FIFO queue of signed 32-bit values with removal of the greatest entry.
// Channels: req (valid/ready, mode + value_in), rsp (valid/ready, removed
// value, front, max, count, status). One response per request.
// Entries sit in a chain of cells; the front is cell 0. Push writes the
// first free cell, pop and remove close the gap by moving the cells behind
// it up. The front and the greatest entry are found by rotating the
// occupied cells once past a comparator at the front, one entry per cycle.
// A push, pop or query that leaves entries in the queue rotates them once;
// remove greatest rotates to find the greatest entry, closes it out, then
// rotates the entries left, if any.
// The next request is taken in the cycle after the response is loaded;
// the rotation scan sets the throughput.
// Reset empties the queue and clears the response valid flag; entry data is
// not cleared. A stalled response holds in its output register while the
// next request is accepted and processed; that result waits in the done
// state until the output register frees.
// Depends on fqmr_pkg, fqmr_req_if, fqmr_rsp_if, fqmr_cell.
`timescale 1ns / 1ps
`default_nettype none

module fifo_queue_with_max_removal_unit #(
    parameter int QUEUE_DEPTH = fqmr_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    fqmr_req_if.sink    req,
    fqmr_rsp_if.source  rsp
);
    import fqmr_pkg::*;

    localparam int            CW      = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);
    localparam logic [CW-1:0] ONE_C   = CW'(1);

    state_t                   state_reg, state_next;
    logic [CW-1:0]            count_reg, count_next;
    logic [CW-1:0]            scan_reg, scan_next;
    logic [CW-1:0]            best_pos_reg, best_pos_next;
    logic signed [DATA_W-1:0] best_val_reg, best_val_next;
    logic signed [DATA_W-1:0] front_reg, front_next;
    logic signed [DATA_W-1:0] removed_reg, removed_next;
    status_t                  status_reg, status_next;
    logic                     pend_reg, pend_next;

    logic                     rsp_valid_reg;
    logic signed [DATA_W-1:0] rsp_removed_reg;
    logic signed [DATA_W-1:0] rsp_front_reg;
    logic signed [DATA_W-1:0] rsp_max_reg;
    logic [COUNT_OUT_W-1:0]   rsp_count_reg;
    logic [STATUS_W-1:0]      rsp_status_reg;

    chain_ctrl_t              chain_ctrl;
    logic [CW-1:0]            chain_pos;
    logic signed [DATA_W-1:0] cell_val [QUEUE_DEPTH];
    logic signed [DATA_W-1:0] head;
    logic                     accept;
    logic                     scan_last;
    logic                     load_out;

    assign head      = cell_val[0];
    assign req.ready = (state_reg == S_IDLE);
    assign accept    = req.valid && req.ready;
    assign scan_last = (scan_reg == (count_reg - ONE_C));
    assign load_out  = (state_reg == S_DONE) && (!rsp_valid_reg || rsp.ready);

    // Entry chain
    for (genvar i = 0; i < QUEUE_DEPTH; i++)
    begin : g_cell
        logic signed [DATA_W-1:0] right_val;
        if (i == QUEUE_DEPTH - 1)
        begin : g_last
            assign right_val = cell_val[i];
        end
        else
        begin : g_mid
            assign right_val = cell_val[i+1];
        end

        fqmr_cell #(
            .IDX (i),
            .CW  (CW)
        ) u_cell (
            .clk   (clk),
            .ctrl  (chain_ctrl),
            .pos   (chain_pos),
            .right (right_val),
            .head  (head),
            .value (cell_val[i])
        );
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = (count_next != '0) ? S_SCAN : S_DONE;
                end
            end
            S_SCAN:
            begin
                if (scan_last)
                begin
                    state_next = pend_reg ? S_REMOVE : S_DONE;
                end
            end
            S_REMOVE:
            begin
                state_next = (count_reg != ONE_C) ? S_SCAN : S_DONE;
            end
            S_DONE:
            begin
                if (load_out)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State outputs: chain command
    always_comb
    begin
        chain_ctrl.op   = CHAIN_HOLD;
        chain_ctrl.data = req.value_in;
        chain_pos       = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if ((mode_t'(req.mode) == MODE_PUSH) && (count_reg < DEPTH_C))
                    begin
                        chain_ctrl.op = CHAIN_PUSH;
                        chain_pos     = count_reg;
                    end
                    else if ((mode_t'(req.mode) == MODE_POP) && (count_reg != '0))
                    begin
                        chain_ctrl.op = CHAIN_CLOSE;
                        chain_pos     = '0;
                    end
                end
            end
            S_SCAN:
            begin
                chain_ctrl.op = CHAIN_ROTATE;
                chain_pos     = count_reg - ONE_C;
            end
            S_REMOVE:
            begin
                chain_ctrl.op = CHAIN_CLOSE;
                chain_pos     = best_pos_reg;
            end
            S_DONE:
            begin
                chain_ctrl.op = CHAIN_HOLD;
            end
            default:
            begin
                chain_ctrl.op = CHAIN_HOLD;
            end
        endcase
    end

    // Datapath next values
    always_comb
    begin
        count_next    = count_reg;
        scan_next     = scan_reg;
        best_pos_next = best_pos_reg;
        best_val_next = best_val_reg;
        front_next    = front_reg;
        removed_next  = removed_reg;
        status_next   = status_reg;
        pend_next     = pend_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    status_next  = STATUS_OK;
                    removed_next = VALUE_ZERO;
                    pend_next    = 1'b0;
                    scan_next    = '0;
                    unique case (mode_t'(req.mode))
                        MODE_PUSH:
                        begin
                            if (count_reg < DEPTH_C)
                            begin
                                count_next = count_reg + ONE_C;
                            end
                            else
                            begin
                                status_next = STATUS_FULL;
                            end
                        end
                        MODE_POP:
                        begin
                            if (count_reg != '0)
                            begin
                                removed_next = head;
                                count_next   = count_reg - ONE_C;
                            end
                            else
                            begin
                                status_next = STATUS_EMPTY;
                            end
                        end
                        MODE_REMOVE_MAX:
                        begin
                            if (count_reg != '0)
                            begin
                                pend_next = 1'b1;
                            end
                            else
                            begin
                                status_next = STATUS_EMPTY;
                            end
                        end
                        MODE_QUERY:
                        begin
                            status_next = STATUS_OK;
                        end
                        default:
                        begin
                            status_next = STATUS_OK;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                // strict compare keeps the earliest of tied maxima
                if ((scan_reg == '0) || (head > best_val_reg))
                begin
                    best_val_next = head;
                    best_pos_next = scan_reg;
                end
                if (scan_reg == '0)
                begin
                    front_next = head;
                end
                scan_next = scan_last ? '0 : (scan_reg + ONE_C);
            end
            S_REMOVE:
            begin
                removed_next = best_val_reg;
                count_next   = count_reg - ONE_C;
                pend_next    = 1'b0;
            end
            S_DONE:
            begin
                pend_next = 1'b0;
            end
            default:
            begin
                pend_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            scan_reg      <= '0;
            pend_reg      <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            scan_reg  <= scan_next;
            pend_reg  <= pend_next;
            if (load_out)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        best_pos_reg <= best_pos_next;
        best_val_reg <= best_val_next;
        front_reg    <= front_next;
        removed_reg  <= removed_next;
        status_reg   <= status_next;
        if (load_out)
        begin
            rsp_removed_reg <= removed_reg;
            rsp_front_reg   <= (count_reg == '0) ? FRONT_EMPTY : front_reg;
            rsp_max_reg     <= (count_reg == '0) ? VALUE_ZERO : best_val_reg;
            rsp_count_reg   <= COUNT_OUT_W'(count_reg);
            rsp_status_reg  <= status_reg;
        end
    end

    assign rsp.valid         = rsp_valid_reg;
    assign rsp.removed_value = rsp_removed_reg;
    assign rsp.front_value   = rsp_front_reg;
    assign rsp.max_value     = rsp_max_reg;
    assign rsp.entry_count   = rsp_count_reg;
    assign rsp.status        = rsp_status_reg;

endmodule

`default_nettype wire

### verif/tb_fifo_queue_with_max_removal_unit.sv
// Testbench for fifo_queue_with_max_removal_unit: directed table, then random requests
// checked against a queue model. Uses fqmr_pkg, fqmr_req_if and fqmr_rsp_if from the RTL.
`timescale 1ns / 1ps

module tb_fifo_queue_with_max_removal_unit;
    import fqmr_pkg::*;

    localparam int DEPTH          = QUEUE_DEPTH_DEF;
    localparam int RAND_PER_PHASE = 300;
    localparam int NUM_PHASES     = 4;
    localparam int DRAIN_CYCLES   = 2 * DEPTH + 40;
    localparam int MAX_REPORTS    = 10;

    localparam logic signed [DATA_W-1:0] INT_MAX = 32'sh7FFFFFFF;
    localparam logic signed [DATA_W-1:0] INT_MIN = 32'sh80000000;

    typedef struct packed {
        logic signed [DATA_W-1:0] removed;
        logic signed [DATA_W-1:0] front;
        logic signed [DATA_W-1:0] maxv;
        logic [COUNT_OUT_W-1:0]   count;
        status_t                  status;
    } snapshot_t;

    // One line of the directed table; want is used only when fixed is set.
    typedef struct packed {
        mode_t                    mode;
        logic signed [DATA_W-1:0] value;
        logic [7:0]               reps;
        logic                     fixed;
        snapshot_t                want;
    } op_row_t;

    localparam snapshot_t NO_WANT = '{VALUE_ZERO, VALUE_ZERO, VALUE_ZERO, 5'd0, STATUS_OK};

    logic clk;
    logic rst_n;

    fqmr_req_if req_ch ();
    fqmr_rsp_if rsp_ch ();

    fifo_queue_with_max_removal_unit #(
        .QUEUE_DEPTH (DEPTH)
    ) uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    logic signed [DATA_W-1:0] queue_model[$];
    snapshot_t                pending_snapshots[$];
    op_row_t                  dir_rows[$];
    int                       send_idle_pct  = 0;
    int                       recv_stall_pct = 0;
    int                       err_count      = 0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("Some tests failed");
        $finish;
    end

    // Earliest entry holding the greatest value; queue must not be empty.
    function automatic int greatest_index();
        int best;
        best = 0;
        for (int i = 1; i < queue_model.size(); i++)
        begin
            if (queue_model[i] > queue_model[best])
                best = i;
        end
        return best;
    endfunction

    function automatic snapshot_t model_apply(mode_t m, logic signed [DATA_W-1:0] v);
        snapshot_t s;
        int        pos;
        s = NO_WANT;
        case (m)
            MODE_PUSH:
            begin
                if (queue_model.size() >= DEPTH)
                    s.status = STATUS_FULL;
                else
                    queue_model.push_back(v);
            end
            MODE_POP, MODE_REMOVE_MAX:
            begin
                if (queue_model.size() == 0)
                    s.status = STATUS_EMPTY;
                else
                begin
                    pos = (m == MODE_POP) ? 0 : greatest_index();
                    s.removed = queue_model[pos];
                    queue_model.delete(pos);
                end
            end
            default: ;
        endcase
        if (queue_model.size() == 0)
        begin
            s.front = FRONT_EMPTY;
            s.maxv  = VALUE_ZERO;
        end
        else
        begin
            s.front = queue_model[0];
            s.maxv  = queue_model[greatest_index()];
        end
        s.count = COUNT_OUT_W'(queue_model.size());
        return s;
    endfunction

    // Small values give ties for the greatest entry.
    function automatic logic signed [DATA_W-1:0] rand_value();
        logic signed [DATA_W-1:0] v;
        case ($urandom_range(3))
            0: v = $urandom_range(8) - 4;
            1:
            begin
                case ($urandom_range(3))
                    0: v = INT_MAX;
                    1: v = INT_MIN;
                    2: v = FRONT_EMPTY;
                    default: v = VALUE_ZERO;
                endcase
            end
            default: v = $urandom;
        endcase
        return v;
    endfunction

    task automatic note_mismatch(input string msg);
        err_count++;
        if (err_count <= MAX_REPORTS)
            $display("%s", msg);
    endtask

    // Called at a clock edge; returns at the edge where the request is taken.
    task automatic send_op(input mode_t m, input logic signed [DATA_W-1:0] v,
                           input logic fixed, input snapshot_t want);
        snapshot_t predicted;
        if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        req_ch.valid    <= 1'b1;
        req_ch.mode     <= m;
        req_ch.value_in <= v;
        do
            @(posedge clk);
        while (!req_ch.ready);
        predicted = model_apply(m, v);
        pending_snapshots.push_back(fixed ? want : predicted);
    endtask

    initial
    begin
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        snapshot_t got;
        snapshot_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            got.removed = rsp_ch.removed_value;
            got.front   = rsp_ch.front_value;
            got.maxv    = rsp_ch.max_value;
            got.count   = rsp_ch.entry_count;
            got.status  = status_t'(rsp_ch.status);
            if (pending_snapshots.size() == 0)
                note_mismatch($sformatf("%0t: response with no request pending", $realtime));
            else
            begin
                want = pending_snapshots.pop_front();
                if (got.removed !== want.removed || got.front !== want.front ||
                    got.maxv !== want.maxv || got.count !== want.count ||
                    got.status !== want.status)
                    note_mismatch($sformatf(
                        "%0t: got rem %0d front %0d max %0d cnt %0d st %0d, exp %0d %0d %0d %0d %0d",
                        $realtime, got.removed, got.front, got.maxv, got.count, got.status,
                        want.removed, want.front, want.maxv, want.count, want.status));
            end
        end
    end

    initial
    begin
        op_row_t row;
        mode_t   m;
        logic    filling;
        int      trend_left;
        int      pick;
        int      push_pct;

        rst_n           = 1'b0;
        req_ch.valid    = 1'b0;
        req_ch.mode     = MODE_QUERY;
        req_ch.value_in = VALUE_ZERO;
        filling         = 1'b1;
        trend_left      = 0;

        // Empty queue, extremes, tie for greatest, fill to full, refused push.
        dir_rows.push_back('{MODE_QUERY, VALUE_ZERO, 8'd1, 1'b1,
                             '{VALUE_ZERO, FRONT_EMPTY, VALUE_ZERO, 5'd0, STATUS_OK}});
        dir_rows.push_back('{MODE_POP, 32'sh12345678, 8'd1, 1'b1,
                             '{VALUE_ZERO, FRONT_EMPTY, VALUE_ZERO, 5'd0, STATUS_EMPTY}});
        dir_rows.push_back('{MODE_REMOVE_MAX, VALUE_ZERO, 8'd1, 1'b1,
                             '{VALUE_ZERO, FRONT_EMPTY, VALUE_ZERO, 5'd0, STATUS_EMPTY}});
        dir_rows.push_back('{MODE_PUSH, INT_MAX, 8'd1, 1'b1,
                             '{VALUE_ZERO, INT_MAX, INT_MAX, 5'd1, STATUS_OK}});
        dir_rows.push_back('{MODE_PUSH, INT_MIN, 8'd1, 1'b1,
                             '{VALUE_ZERO, INT_MAX, INT_MAX, 5'd2, STATUS_OK}});
        dir_rows.push_back('{MODE_PUSH, FRONT_EMPTY, 8'd1, 1'b0, NO_WANT});
        dir_rows.push_back('{MODE_PUSH, INT_MAX, 8'd1, 1'b0, NO_WANT});
        dir_rows.push_back('{MODE_REMOVE_MAX, VALUE_ZERO, 8'd1, 1'b0, NO_WANT});
        dir_rows.push_back('{MODE_POP, VALUE_ZERO, 8'd1, 1'b0, NO_WANT});
        dir_rows.push_back('{MODE_PUSH, 32'shAAAAAAAA, 8'd7, 1'b0, NO_WANT});
        dir_rows.push_back('{MODE_PUSH, 32'sh55555555, 8'd7, 1'b0, NO_WANT});
        dir_rows.push_back('{MODE_PUSH, VALUE_ZERO, 8'd1, 1'b0, NO_WANT});
        dir_rows.push_back('{MODE_QUERY, FRONT_EMPTY, 8'd1, 1'b0, NO_WANT});
        dir_rows.push_back('{MODE_REMOVE_MAX, VALUE_ZERO, 8'd1, 1'b0, NO_WANT});

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
        begin
            row = dir_rows[i];
            repeat (row.reps) send_op(row.mode, row.value, row.fixed, row.want);
        end

        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            case (phase)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 47; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 47; end
                default: begin send_idle_pct = 38; recv_stall_pct = 38; end
            endcase
            for (int n = 0; n < RAND_PER_PHASE; n++)
            begin
                // alternate fill and drain stretches so full and empty both come up
                if (trend_left == 0)
                begin
                    filling    = !filling;
                    trend_left = $urandom_range(40, 12);
                end
                trend_left--;
                push_pct = filling ? 65 : 25;
                pick     = $urandom_range(99);
                if (pick < push_pct)
                    m = MODE_PUSH;
                else if (pick < 92)
                    m = $urandom_range(1) ? MODE_POP : MODE_REMOVE_MAX;
                else
                    m = MODE_QUERY;
                send_op(m, rand_value(), 1'b0, NO_WANT);
            end
        end
        req_ch.valid <= 1'b0;

        while (pending_snapshots.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (err_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
